// ===== rtl/pmq_pkg.sv =====
// Package for the priority message queue.
// Holds the operation, status and state codes and the controller/datapath interface types.
// No dependencies.
package pmq_pkg;

    localparam logic [1:0] KIND_PUT   = 2'd0;
    localparam logic [1:0] KIND_GET   = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic take;
    } dp_cmd_t;

    typedef struct packed {
        logic out_full;
    } dp_status_t;

endpackage

// ===== rtl/pmq_datapath.sv =====
// Datapath of the priority message queue: sorted slot cells, count, request and result registers.
// Depends on pmq_pkg.
module pmq_datapath #(
    parameter int DEPTH         = 16,
    parameter int PAYLOAD_WIDTH = 32,
    parameter int CW            = $clog2(DEPTH + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  pmq_pkg::dp_cmd_t   cmd,
    output pmq_pkg::dp_status_t stat,
    input  logic               cfg_we,
    input  logic [4:0]         cfg_data,
    input  logic [1:0]         kind,
    input  logic [7:0]         priority_req,
    input  logic [31:0]        payload,
    output logic [1:0]         status,
    output logic [7:0]         out_priority,
    output logic [31:0]        out_payload,
    output logic [4:0]         count_after
);

    localparam int PW = (PAYLOAD_WIDTH < 32) ? PAYLOAD_WIDTH : 32;

    logic [7:0]               prio_reg [DEPTH];
    logic [PAYLOAD_WIDTH-1:0] body_reg [DEPTH];
    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            count_next;
    logic [4:0]               cap_reg;
    logic [1:0]               kind_reg;
    logic [7:0]               rprio_reg;
    logic [PAYLOAD_WIDTH-1:0] rbody_reg;
    logic                     full_reg;
    logic                     full_next;
    logic [1:0]               status_next;
    logic [7:0]               oprio_next;
    logic [31:0]              obody_next;
    logic                     room;
    logic [DEPTH-1:0]         occ;
    logic [DEPTH-1:0]         lower;

    assign stat.out_full = full_reg;
    assign room = ({{(32-CW){1'b0}}, count_reg} < 32'(cap_reg)) &&
                  ({{(32-CW){1'b0}}, count_reg} < 32'(DEPTH));

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            occ[i]   = 32'(i) < {{(32-CW){1'b0}}, count_reg};
            lower[i] = occ[i] && (prio_reg[i] < rprio_reg);
        end
    end

    always_comb
    begin
        count_next  = count_reg;
        status_next = pmq_pkg::ST_OK;
        oprio_next  = 8'd0;
        obody_next  = 32'd0;
        case (kind_reg)
            pmq_pkg::KIND_PUT:
            begin
                if (room)
                    count_next = count_reg + 1'b1;
                else
                    status_next = pmq_pkg::ST_FULL;
            end
            pmq_pkg::KIND_GET:
            begin
                if (count_reg == '0)
                    status_next = pmq_pkg::ST_EMPTY;
                else
                begin
                    count_next = count_reg - 1'b1;
                    oprio_next = prio_reg[0];
                    obody_next = 32'(body_reg[0][PW-1:0]);
                end
            end
            pmq_pkg::KIND_CLEAR: count_next = '0;
            default: count_next = count_reg;
        endcase
    end

    always_comb
    begin
        full_next = full_reg;
        if (cmd.take)
            full_next = 1'b0;
        if (cmd.exec)
            full_next = 1'b1;
    end

    // Each cell inserts, shifts right, or shifts left by looking at its own and its left neighbor.
    always_ff @(posedge clk)
    begin
        if (cmd.exec && kind_reg == pmq_pkg::KIND_PUT && room)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                if (i == 0)
                begin
                    if (lower[0] || !occ[0])
                    begin
                        prio_reg[0] <= rprio_reg;
                        body_reg[0] <= rbody_reg;
                    end
                end
                else if (lower[i - 1])
                begin
                    prio_reg[i] <= prio_reg[i - 1];
                    body_reg[i] <= body_reg[i - 1];
                end
                else if (lower[i] || !occ[i])
                begin
                    prio_reg[i] <= rprio_reg;
                    body_reg[i] <= rbody_reg;
                end
            end
        end
        else if (cmd.exec && kind_reg == pmq_pkg::KIND_GET)
        begin
            for (int i = 0; i < DEPTH - 1; i++)
            begin
                prio_reg[i] <= prio_reg[i + 1];
                body_reg[i] <= body_reg[i + 1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg  <= kind;
            rprio_reg <= priority_req;
            rbody_reg <= PAYLOAD_WIDTH'({{(PAYLOAD_WIDTH > 32 ? PAYLOAD_WIDTH - 32 : 1){1'b0}},
                                          payload});
        end
        if (cmd.exec)
        begin
            status       <= status_next;
            out_priority <= oprio_next;
            out_payload  <= obody_next;
            count_after  <= 5'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            cap_reg   <= 5'd16;
            full_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.exec)
                count_reg <= count_next;
            if (cfg_we)
                cap_reg <= cfg_data;
            full_reg <= full_next;
        end
    end

endmodule

// ===== rtl/pmq_ctrl.sv =====
// Controller of the priority message queue: request capture, execute and result handoff.
// Depends on pmq_pkg.
module pmq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                out_ready,
    output logic                out_valid,
    input  pmq_pkg::dp_status_t stat,
    output pmq_pkg::dp_cmd_t    cmd
);

    pmq_pkg::state_t state_reg;
    pmq_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= pmq_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // A new request is taken while the previous result still waits.
    always_comb
    begin
        state_next = state_reg;
        out_valid  = stat.out_full;
        cmd.take   = stat.out_full && out_ready;
        in_ready   = 1'b0;
        cmd.load   = 1'b0;
        cmd.exec   = 1'b0;
        case (state_reg)
            pmq_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = pmq_pkg::S_EXEC;
                end
            end
            pmq_pkg::S_EXEC:
            begin
                if (!stat.out_full || out_ready)
                begin
                    cmd.exec   = 1'b1;
                    state_next = pmq_pkg::S_IDLE;
                end
            end
            default: state_next = pmq_pkg::S_IDLE;
        endcase
    end

endmodule

// ===== rtl/priority_message_queue.sv =====
// Top level of the priority message queue.
// Depends on pmq_pkg, pmq_ctrl and pmq_datapath.
//
//   Channel   Handshake               Fields
//   request   in_valid / in_ready     kind, priority_req, payload
//   result    out_valid / out_ready   status, out_priority, out_payload, count_after
//   config    cfg_we                  cfg_data (capacity)
//
// Each request is first captured, then the sorted cells insert or shift in parallel
// and register the result once the output register is free to take it.
// The next request is captured while a result still waits in the output register.
// Reset empties the queue and sets the capacity to 16; no clearing pass is needed.
module priority_message_queue #(
    parameter int DEPTH         = 16,
    parameter int PAYLOAD_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [7:0]  priority_req,
    input  logic [31:0] payload,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [7:0]  out_priority,
    output logic [31:0] out_payload,
    output logic [4:0]  count_after
);

    pmq_pkg::dp_cmd_t    cmd;
    pmq_pkg::dp_status_t stat;

    pmq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .stat      (stat),
        .cmd       (cmd)
    );

    pmq_datapath #(
        .DEPTH         (DEPTH),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .kind         (kind),
        .priority_req (priority_req),
        .payload      (payload),
        .status       (status),
        .out_priority (out_priority),
        .out_payload  (out_payload),
        .count_after  (count_after)
    );

endmodule
